>>> design/jpeg_run_size_coeff_expander_defines.svh
// Assertion macros for the run/size coefficient expander.
// No dependencies; included by the checker.
`ifndef JPEG_RUN_SIZE_COEFF_EXPANDER_DEFINES_SVH
`define JPEG_RUN_SIZE_COEFF_EXPANDER_DEFINES_SVH

// same-cycle implication
`define JRSCE_AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jrsce: check failed");

// next-cycle implication
`define JRSCE_AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jrsce: check failed");

`endif

>>> design/jrsce_pkg.sv
// Shared widths and controller/datapath interface types.
// No dependencies.
`default_nettype none
package jrsce_pkg;
    localparam int SymW  = 8;
    localparam int MagW  = 15;
    localparam int CoefW = 16;
    localparam int PosW  = 6;
    localparam int NibW  = 4;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic res_last;
    } t_sts;
endpackage
`default_nettype wire

>>> design/jrsce_ctrl.sv
// Sequencer: takes one item, then steps the datapath once per result.
// Depends on jrsce_pkg.
`default_nettype none
module jrsce_ctrl
    import jrsce_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.step = i_sts.out_free;
                if (i_sts.out_free && i_sts.res_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule
`default_nettype wire

>>> design/jrsce_dp.sv
// Datapath: block position, run counter, value decode and output register.
// Depends on jrsce_pkg.
`default_nettype none
module jrsce_dp
    import jrsce_pkg::*;
#(
    parameter int BLOCK_SIZE = 64
)(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  wire        [SymW-1:0]   i_symbol,
    input  wire        [MagW-1:0]   i_magnitude_bits,
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic signed [CoefW-1:0] o_coefficient,
    output logic       [PosW-1:0]   o_position,
    output logic                    o_block_done,
    output logic                    o_overrun,
    output logic                    o_last
);
    localparam logic [PosW-1:0] LastPos = PosW'(BLOCK_SIZE - 1);
    localparam logic [PosW:0]   BlkSz   = (PosW+1)'(BLOCK_SIZE);

    logic [PosW-1:0]  r_pos;
    logic [NibW-1:0]  r_run;
    logic [CoefW-1:0] r_value;
    logic             r_fill;
    logic             r_ovr;
    logic             r_valid;

    logic [NibW-1:0]  in_run, in_nbits;
    logic [MagW-1:0]  mask, v;
    logic             sgn, cut, fin, cur_last;
    logic [PosW:0]    sum;
    logic [CoefW-1:0] dec;

    always_comb begin
        in_run   = i_symbol[SymW-1:NibW];
        in_nbits = i_symbol[NibW-1:0];
        mask     = {MagW{1'b1}} >> (4'd15 - in_nbits);
        v        = i_magnitude_bits & mask;
        sgn      = |(v & ~(mask >> 1));
        dec      = sgn ? {1'b0, v} : ({1'b0, v} - {1'b0, mask});
        sum      = {1'b0, r_pos} + {{(PosW+1-NibW){1'b0}}, in_run};
        cut      = (i_symbol != '0) && (sum >= BlkSz);
        fin      = (r_pos == LastPos);
        cur_last = r_fill ? fin : (r_run == '0);
    end

    assign o_sts.out_free = !r_valid || !i_stall;
    assign o_sts.res_last = cur_last;
    assign o_valid        = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_pos   <= fin ? '0 : r_pos + 1'b1;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_run   <= in_run;
            r_value <= dec;
            r_fill  <= ((i_symbol == '0) && (r_pos != '0)) || cut;
            r_ovr   <= cut;
        end else if (i_cmd.step && (r_run != '0)) begin
            r_run <= r_run - 1'b1;
        end
        if (i_cmd.step) begin
            o_coefficient <= (r_fill || (r_run != '0)) ? '0 : r_value;
            o_position    <= r_pos;
            o_block_done  <= fin;
            o_overrun     <= r_fill && r_ovr && fin;
            o_last        <= cur_last;
        end
    end
endmodule
`default_nettype wire

>>> design/jpeg_run_size_coeff_expander.sv
// Top level: run/size symbol to zig-zag coefficient expander.
// Depends on jrsce_pkg, jrsce_ctrl, jrsce_dp.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------------------
//  in      | input     | i_valid / o_stall | i_symbol, i_magnitude_bits
//  out     | output    | o_valid / i_stall | o_coefficient, o_position,
//          |           |                   | o_block_done, o_overrun, o_last
//
// An item is accepted, then gives one result per step: run+1 results,
// or the zeros up to block end on end of block or a cut run.
// The single output register sets the pace: one result per cycle, held on stall.
// Reset (synchronous, active low) clears the sequencer state, block position and output valid flag.
// No new item is taken until the item's last result is in the output register.
`default_nettype none
module jpeg_run_size_coeff_expander
    import jrsce_pkg::*;
#(
    parameter int BLOCK_SIZE = 64
)(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire        [SymW-1:0]   i_symbol,
    input  wire        [MagW-1:0]   i_magnitude_bits,
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic signed [CoefW-1:0] o_coefficient,
    output logic       [PosW-1:0]   o_position,
    output logic                    o_block_done,
    output logic                    o_overrun,
    output logic                    o_last
);
    t_cmd cmd;
    t_sts sts;

    jrsce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    jrsce_dp #(.BLOCK_SIZE(BLOCK_SIZE)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_symbol         (i_symbol),
        .i_magnitude_bits (i_magnitude_bits),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_coefficient    (o_coefficient),
        .o_position       (o_position),
        .o_block_done     (o_block_done),
        .o_overrun        (o_overrun),
        .o_last           (o_last)
    );
endmodule
`default_nettype wire

>>> design/jrsce_chk.sv
// Port-level checker for the coefficient expander, bound to the top level.
// Depends on jpeg_run_size_coeff_expander_defines.svh and jrsce_pkg.
`default_nettype none
`include "jpeg_run_size_coeff_expander_defines.svh"
module jrsce_chk
    import jrsce_pkg::*;
#(
    parameter int BLOCK_SIZE = 64
)(
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     o_valid,
    input wire                     i_stall,
    input wire signed [CoefW-1:0]  o_coefficient,
    input wire        [PosW-1:0]   o_position,
    input wire                     o_block_done,
    input wire                     o_overrun,
    input wire                     o_last
);
    localparam logic [PosW-1:0] LastPos = PosW'(BLOCK_SIZE - 1);

    `JRSCE_AST_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_coefficient) && $stable(o_position))
    `JRSCE_AST_IMP(a_done_pos, i_clk, i_rst_n, o_valid, o_block_done == (o_position == LastPos))
    `JRSCE_AST_IMP(a_ovr_end, i_clk, i_rst_n, o_valid && o_overrun, o_last && o_block_done)
    `JRSCE_AST_IMP(a_val_last, i_clk, i_rst_n, o_valid && (o_coefficient != '0), o_last && !o_overrun)
endmodule

bind jpeg_run_size_coeff_expander jrsce_chk #(.BLOCK_SIZE(BLOCK_SIZE)) u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_coefficient (o_coefficient),
    .o_position    (o_position),
    .o_block_done  (o_block_done),
    .o_overrun     (o_overrun),
    .o_last        (o_last)
);
`default_nettype wire
